/* rtl/rrd_pkg.sv */
// ----------------------------------------------------------------------------
// Round-robin dispatcher package
// Sizes, transaction payload types and a helper function that the channel
// interfaces and the dispatcher share.
// ----------------------------------------------------------------------------
package rrd_pkg;

	localparam int NUM_JOBS   = 4;
	localparam int TIME_WIDTH = 16;
	localparam int JOB_W      = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
	localparam int CAND_W     = JOB_W + 1;
	localparam int TOTAL_W    = TIME_WIDTH + $clog2(NUM_JOBS);
	localparam int SLICE_W    = TIME_WIDTH + 8;
	localparam int TOTAL_OUT_W = 18;
	localparam int SAT_W      = TOTAL_W + TOTAL_OUT_W;
	localparam int PADDR_W    = 3;

	localparam logic [TOTAL_OUT_W-1:0] TOTAL_MAX = '1;
	localparam logic [7:0] QUANTUM_RESET = 8'd2;

	typedef enum logic {
		OP_LOAD     = 1'b0,
		OP_DISPATCH = 1'b1
	} op_t;

	typedef enum logic {
		REG_QUANTUM = 1'b0,
		REG_NONE    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic        op;
		logic [1:0]  job_index;
		logic [15:0] burst_time;
	} cmd_t;

	typedef struct packed {
		logic [1:0]             job_id;
		logic [7:0]             slice_used;
		logic                   job_finished;
		logic                   idle;
		logic [TOTAL_OUT_W-1:0] total_left;
	} res_t;

	// Clamp the exact internal total to the reported field width.
	function automatic logic [TOTAL_OUT_W-1:0] sat_total(input logic [TOTAL_W-1:0] total);
		logic [SAT_W-1:0] wide;
		wide = SAT_W'(total);
		if (wide > SAT_W'(TOTAL_MAX)) begin
			return TOTAL_MAX;
		end
		return wide[TOTAL_OUT_W-1:0];
	endfunction

endpackage

/* rtl/rrd_cmd_if.sv */
// ----------------------------------------------------------------------------
// Round-robin dispatcher command channel
// Valid/ready channel that carries load and dispatch transactions.
// ----------------------------------------------------------------------------
interface rrd_cmd_if;
	logic         valid;
	logic         ready;
	rrd_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rrd_res_if.sv */
// ----------------------------------------------------------------------------
// Round-robin dispatcher result channel
// Valid/ready channel that carries one result per dispatch transaction.
// ----------------------------------------------------------------------------
interface rrd_res_if;
	logic         valid;
	logic         ready;
	rrd_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/round_robin_dispatcher.sv */
// ----------------------------------------------------------------------------
// Round-robin time-slice dispatcher
// Keeps the remaining run time of a small job table and hands out time
// slices to the jobs in circular order.
// ----------------------------------------------------------------------------
// Usage:
// The cmd channel takes load and dispatch transactions. A load writes the
// remaining time of one job and produces no result. A dispatch picks the
// next job with time left after the one served last, charges it the smaller
// of the quantum and its remaining time, and returns one transaction on the
// res channel; with no work left it returns an idle result.
// The quantum register sits at byte address 0 of the APB port.
// Sequencing: the input is ready only in the idle state, so a transaction is
// taken only once the last one has executed. The remaining times live in a
// synchronous memory: the entry is read at the accept edge and written back
// in the execute state. A dispatch result is registered when its execute
// state commits and is then held in the result register until taken.
// Reset empties the job table (per-job busy flags clear at once, so the
// memory needs no clearing pass), sets the search pointer to job 0 and the
// quantum to 2. When the receiver stalls, the result register holds its
// transaction; loads still go through, and the next dispatch is accepted but
// waits in its execute cycle until the result is taken, blocking the input.
// ----------------------------------------------------------------------------
module round_robin_dispatcher (
	input  logic                        clk,
	input  logic                        arst_n,
	rrd_cmd_if.sink                     cmd,
	rrd_res_if.source                   res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rrd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	// Two-state sequencer: accept (and read the memory), then execute.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	// Configuration register.
	logic [7:0] quantum_q;

	// Job table: remaining times in memory, busy flags in flip-flops.
	// A job whose busy flag is clear reads as zero remaining time.
	logic [rrd_pkg::TIME_WIDTH-1:0] time_mem_q [rrd_pkg::NUM_JOBS];
	logic [rrd_pkg::NUM_JOBS-1:0]   busy_q;
	logic [rrd_pkg::JOB_W-1:0]      ptr_q;
	logic [rrd_pkg::TOTAL_W-1:0]    total_q;

	// Transaction captured at the accept edge.
	logic                           op_s1;
	logic                           load_ok_s1;
	logic [rrd_pkg::JOB_W-1:0]      addr_s1;
	logic [rrd_pkg::TIME_WIDTH-1:0] burst_s1;
	logic                           found_s1;
	logic [rrd_pkg::TIME_WIDTH-1:0] rd_data_s1;

	// Result register.
	logic          out_valid_q;
	rrd_pkg::res_t out_q;

	logic                           cmd_fire;
	logic                           exec_go;
	logic                           found;
	logic [rrd_pkg::JOB_W-1:0]      slot;
	logic [rrd_pkg::CAND_W-1:0]     cand;
	logic                           load_ok;
	logic [rrd_pkg::JOB_W-1:0]      rd_addr;
	logic [rrd_pkg::TIME_WIDTH-1:0] rem;
	logic [rrd_pkg::SLICE_W-1:0]    rem_w;
	logic [rrd_pkg::SLICE_W-1:0]    quant_w;
	logic [rrd_pkg::SLICE_W-1:0]    slice_w;
	logic [rrd_pkg::TIME_WIDTH-1:0] new_rem;
	logic [rrd_pkg::TOTAL_W-1:0]    disp_total;
	logic [rrd_pkg::TOTAL_W-1:0]    load_total;
	logic [rrd_pkg::JOB_W-1:0]      next_ptr;
	logic                           mem_we;
	logic [rrd_pkg::TIME_WIDTH-1:0] mem_wdata;
	logic                           cfg_we;

	// ------------------------------------------------------------------
	// Configuration port. Writes only land on the quantum register when
	// the address selects it; other addresses read back as zero.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready
		&& (paddr[2] == rrd_pkg::REG_QUANTUM);

	always_comb begin
		prdata = '0;
		if (paddr[2] == rrd_pkg::REG_QUANTUM) begin
			prdata = {24'd0, quantum_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= rrd_pkg::QUANTUM_RESET;
		end else if (cfg_we) begin
			quantum_q <= pwdata[7:0];
		end
	end

	// ------------------------------------------------------------------
	// Accept side. The circular search runs over the busy flags, starting
	// at the pointer, so the memory read can already target the chosen job.
	// ------------------------------------------------------------------
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;

	always_comb begin
		found = 1'b0;
		slot  = '0;
		cand  = '0;
		// Walk from the far end down, so the nearest busy job wins.
		for (int k = rrd_pkg::NUM_JOBS - 1; k >= 0; k--) begin
			cand = {1'b0, ptr_q} + rrd_pkg::CAND_W'(k);
			if (cand >= rrd_pkg::CAND_W'(rrd_pkg::NUM_JOBS)) begin
				cand = cand - rrd_pkg::CAND_W'(rrd_pkg::NUM_JOBS);
			end
			if (busy_q[cand[rrd_pkg::JOB_W-1:0]]) begin
				found = 1'b1;
				slot  = cand[rrd_pkg::JOB_W-1:0];
			end
		end
	end

	// A load to a slot outside the table is dropped.
	assign load_ok = (32'(cmd.data.job_index) < rrd_pkg::NUM_JOBS);
	assign rd_addr = (cmd.data.op == rrd_pkg::OP_LOAD)
		? rrd_pkg::JOB_W'(cmd.data.job_index) : slot;

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			op_s1      <= cmd.data.op;
			load_ok_s1 <= load_ok;
			addr_s1    <= rd_addr;
			burst_s1   <= rrd_pkg::TIME_WIDTH'(cmd.data.burst_time);
			found_s1   <= found;
		end
	end

	// ------------------------------------------------------------------
	// Job time memory: read at accept, written in the execute cycle. The
	// next read comes at a later accept, after the write, so no forwarding
	// path is needed.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			time_mem_q[addr_s1] <= mem_wdata;
		end
		if (cmd_fire) begin
			rd_data_s1 <= time_mem_q[rd_addr];
		end
	end

	// ------------------------------------------------------------------
	// Execute cycle: modify the entry that was read.
	// ------------------------------------------------------------------
	assign rem     = busy_q[addr_s1] ? rd_data_s1 : '0;
	assign rem_w   = rrd_pkg::SLICE_W'(rem);
	// A quantum of zero still charges one unit.
	assign quant_w = (quantum_q == 8'd0) ? rrd_pkg::SLICE_W'(1)
		: rrd_pkg::SLICE_W'(quantum_q);
	assign slice_w = (rem_w < quant_w) ? rem_w : quant_w;
	assign new_rem = rem - rrd_pkg::TIME_WIDTH'(slice_w);

	assign disp_total = total_q - rrd_pkg::TOTAL_W'(slice_w);
	assign load_total = total_q - rrd_pkg::TOTAL_W'(rem) + rrd_pkg::TOTAL_W'(burst_s1);

	assign next_ptr = (addr_s1 == rrd_pkg::JOB_W'(rrd_pkg::NUM_JOBS - 1))
		? '0 : addr_s1 + rrd_pkg::JOB_W'(1);

	// A dispatch needs room in the result register before it commits.
	assign exec_go = (state_q == ST_EXEC)
		&& !((op_s1 == rrd_pkg::OP_DISPATCH) && out_valid_q && !res.ready);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = new_rem;
		if (exec_go) begin
			if (op_s1 == rrd_pkg::OP_LOAD) begin
				mem_we    = load_ok_s1;
				mem_wdata = burst_s1;
			end else begin
				mem_we = found_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= '0;
			ptr_q   <= '0;
			total_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
						if (op_s1 == rrd_pkg::OP_LOAD) begin
							if (load_ok_s1) begin
								busy_q[addr_s1] <= (burst_s1 != '0);
								total_q         <= load_total;
							end
						end else if (found_s1) begin
							busy_q[addr_s1] <= (new_rem != '0);
							total_q         <= disp_total;
							ptr_q           <= next_ptr;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go && (op_s1 == rrd_pkg::OP_DISPATCH)) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go && (op_s1 == rrd_pkg::OP_DISPATCH)) begin
			if (found_s1) begin
				out_q.job_id       <= 2'(addr_s1);
				out_q.slice_used   <= slice_w[7:0];
				out_q.job_finished <= (new_rem == '0);
				out_q.idle         <= 1'b0;
				out_q.total_left   <= rrd_pkg::sat_total(disp_total);
			end else begin
				out_q.job_id       <= '0;
				out_q.slice_used   <= '0;
				out_q.job_finished <= 1'b0;
				out_q.idle         <= 1'b1;
				out_q.total_left   <= '0;
			end
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

`ifndef SYNTHESIS
	// The exact total is zero exactly when no job is busy.
	a_total_matches_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q == '0) == (busy_q == '0))
	else $error("total and busy flags disagree");

	// An accepted command always moves the sequencer to execute.
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> (state_q == ST_EXEC))
	else $error("accepted command did not reach execute");

	// An idle result charges nothing and reports no work left.
	a_idle_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.data.idle) |->
			(res.data.slice_used == 8'd0) && (res.data.total_left == '0)
			&& !res.data.job_finished)
	else $error("idle result carries work");

	// A committed dispatch always leaves a result in the register.
	a_dispatch_result: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && (op_s1 == rrd_pkg::OP_DISPATCH)) |=> out_valid_q)
	else $error("dispatch result lost");
`endif

endmodule
